### sv/lfuc_pkg.sv
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared widths, command codes and the controller state type of the LFU cache.
// ----------------------------------------------------------------------------
package lfuc_pkg;

	localparam int CMD_W     = 1;
	localparam int KEY_TAG_W = 32;
	localparam int VALUE_W   = 64;
	localparam int CAP_W     = 5;
	localparam int STAMP_W   = 32;

	localparam logic [CMD_W-1:0] CMD_GET = 1'b0;
	localparam logic [CMD_W-1:0] CMD_SET = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} lfuc_state_t;

endpackage

### sv/lfuc_if.sv
// ----------------------------------------------------------------------------
// lfuc interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lfuc_req_if;
	import lfuc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [KEY_TAG_W-1:0] key_tag;
	logic [VALUE_W-1:0]   write_value;

	modport source (output valid, command, key_tag, write_value, input ready);
	modport sink   (input valid, command, key_tag, write_value, output ready);
endinterface

interface lfuc_rsp_if;
	import lfuc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [VALUE_W-1:0]   read_value;
	logic                 evicted;
	logic [KEY_TAG_W-1:0] evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfuc_cfg_if;
	import lfuc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

### sv/lfu_cache_with_lru_ties_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_ties_unit
// Fully associative LFU cache, ties broken by oldest stamp, entries in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req  : get (command 0) or set (command 1) with key_tag and write_value.
//   rsp  : one response per request: hit, read_value, evicted, evicted_key.
//   cfg  : writes capacity_in_use; always ready, write only while idle.
// Each request walks every entry of the entry RAM, one read per cycle
// through the single registered read port, tracking the key match, the first
// free slot and the eviction candidate (lowest count, then oldest stamp). The
// FINISH state then writes the touched entry back and loads the response
// register; a request with capacity zero skips the scan and goes straight
// to FINISH. The unit returns to IDLE before it takes the next request, so
// one request is in work at a time.
// A new request is taken while the previous response still waits; a stalled
// response holds the finished request in the write-back cycle.
// Reset clears the valid bits, the stamp counter and the response valid flag
// and loads capacity 10. Entry RAM contents need no clearing.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_ties_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	lfuc_req_if.sink   req,
	lfuc_rsp_if.source rsp,
	lfuc_cfg_if.sink   cfg
);

	import lfuc_pkg::*;

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
	localparam int EW   = KEY_BITS + VALUE_BITS + COUNT_BITS + STAMP_W;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] count;
		logic [STAMP_W-1:0]    stamp;
	} entry_t;

	lfuc_state_t state_q, state_d;

	logic [CAP_W-1:0]      cap_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [STAMP_W-1:0]    stamp_q;

	logic [CMD_W-1:0]      cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  off_q;
	logic [CMPW-1:0]       cap_eff_q;

	logic [CW-1:0]         rd_cnt_q;
	logic                  proc_vld_s1;
	logic [IW-1:0]         proc_idx_s1;

	logic [CW-1:0]         used_q;
	logic                  found_q;
	logic [IW-1:0]         found_idx_q;
	logic [VALUE_BITS-1:0] found_value_q;
	logic [COUNT_BITS-1:0] found_count_q;
	logic                  free_found_q;
	logic [IW-1:0]         free_idx_q;
	logic                  vic_found_q;
	logic [IW-1:0]         vic_idx_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [STAMP_W-1:0]    vic_age_q;
	logic [KEY_BITS-1:0]   vic_key_q;

	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_W-1:0]    read_value_q;
	logic                  evicted_q;
	logic [KEY_TAG_W-1:0]  evicted_key_q;

	logic                  in_ready;
	logic                  mem_re;
	logic                  fin_go;
	logic                  accept;
	logic                  scan_last;

	logic [EW-1:0]         mem_rdata;
	entry_t                rd_entry;
	logic [STAMP_W-1:0]    rd_age;
	logic                  rd_valid;
	logic                  vic_better;

	logic                  mem_we;
	logic [IW-1:0]         wr_idx;
	entry_t                wr_entry;
	logic                  hit_d;
	logic [VALUE_W-1:0]    read_value_d;
	logic                  evicted_d;
	logic [KEY_TAG_W-1:0]  evicted_key_d;
	logic                  do_evict;
	logic                  insert;

	// --------------------------------------------------------------- control
	assign accept    = req.valid && in_ready;
	assign scan_last = (rd_cnt_q == CW'(ENTRIES));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (cap_q == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_re   = 1'b0;
		fin_go   = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SCAN:   mem_re   = !scan_last;
			ST_FINISH: fin_go   = !out_valid_q || rsp.ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
		end
	end

	// --------------------------------------------------------------- request
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			key_q <= KEY_BITS'(req.key_tag);
			val_q <= VALUE_BITS'(req.write_value);
			off_q <= (cap_q == '0);
			if (CMPW'(cap_q) > CMPW'(ENTRIES)) begin
				cap_eff_q <= CMPW'(ENTRIES);
			end else begin
				cap_eff_q <= CMPW'(cap_q);
			end
		end
	end

	// ------------------------------------------------------------ entry RAM
	lfuc_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.re    (mem_re),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	// ------------------------------------------------------------------ scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			proc_vld_s1 <= 1'b0;
		end else begin
			proc_vld_s1 <= mem_re;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (mem_re) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			proc_idx_s1 <= rd_cnt_q[IW-1:0];
		end
	end

	assign rd_entry   = entry_t'(mem_rdata);
	assign rd_valid   = proc_vld_s1 && valid_q[proc_idx_s1];
	assign rd_age     = stamp_q - rd_entry.stamp;
	assign vic_better = !vic_found_q
		|| (rd_entry.count < vic_cnt_q)
		|| ((rd_entry.count == vic_cnt_q) && (rd_age > vic_age_q));

	always_ff @(posedge clk) begin
		if (accept) begin
			used_q       <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
		end else if (proc_vld_s1) begin
			if (rd_valid) begin
				used_q <= used_q + 1'b1;
				if (!found_q && (rd_entry.key == key_q)) begin
					found_q       <= 1'b1;
					found_idx_q   <= proc_idx_s1;
					found_value_q <= rd_entry.value;
					found_count_q <= rd_entry.count;
				end
				if (vic_better) begin
					vic_found_q <= 1'b1;
					vic_idx_q   <= proc_idx_s1;
					vic_cnt_q   <= rd_entry.count;
					vic_age_q   <= rd_age;
					vic_key_q   <= rd_entry.key;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= proc_idx_s1;
			end
		end
	end

	// ------------------------------------------------------------ write-back
	assign do_evict = (CMPW'(used_q) >= cap_eff_q) && vic_found_q;
	assign insert   = !off_q && !found_q && (cmd_q == CMD_SET)
		&& (do_evict || free_found_q);

	always_comb begin
		mem_we         = 1'b0;
		wr_idx         = found_idx_q;
		wr_entry.key   = key_q;
		wr_entry.value = val_q;
		wr_entry.count = COUNT_BITS'(1);
		wr_entry.stamp = stamp_q;
		hit_d          = 1'b0;
		read_value_d   = '0;
		evicted_d      = 1'b0;
		evicted_key_d  = '0;
		if (!off_q && found_q) begin
			mem_we = fin_go;
			hit_d  = 1'b1;
			if (cmd_q == CMD_GET) begin
				read_value_d   = VALUE_W'(found_value_q);
				wr_entry.value = found_value_q;
			end
			if (found_count_q != '1) begin
				wr_entry.count = found_count_q + 1'b1;
			end else begin
				wr_entry.count = found_count_q;
			end
		end else if (insert) begin
			mem_we = fin_go;
			if (do_evict) begin
				wr_idx        = vic_idx_q;
				evicted_d     = 1'b1;
				evicted_key_d = KEY_TAG_W'(vic_key_q);
			end else begin
				wr_idx = free_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			stamp_q <= '0;
		end else if (mem_we) begin
			valid_q[wr_idx] <= 1'b1;
			stamp_q         <= stamp_q + 1'b1;
		end
	end

	// -------------------------------------------------------------- response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			hit_q         <= hit_d;
			read_value_q  <= read_value_d;
			evicted_q     <= evicted_d;
			evicted_key_q <= evicted_key_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.evicted     = evicted_q;
	assign rsp.evicted_key = evicted_key_q;

	// ------------------------------------------------------------ assertions
	a_off_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && off_q) |-> !mem_we)
		else $error("write-back on a disabled cache");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.evicted))
		else $error("response reports both hit and eviction");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.hit) |-> (rsp.read_value == '0))
		else $error("nonzero read value without a hit");

	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (stamp_q == $past(stamp_q) + 1'b1))
		else $error("stamp counter did not advance on write-back");

	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !proc_vld_s1)
		else $error("write-back overlaps the entry scan");

endmodule

### sv/lfuc_ram.sv
// ----------------------------------------------------------------------------
// lfuc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfuc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### verif/tb_lfu_cache_with_lru_ties_unit.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_with_lru_ties_unit
// Self-checking bench for the LFU cache with oldest-stamp tie-break. A queue
// of get/set requests feeds a handshake driver. A shadow copy of the cache
// computes each response when its request is taken. Each response is checked
// field by field against the oldest outstanding prediction. Capacity is
// changed between phases while the cache is idle.
// ----------------------------------------------------------------------------
module tb_lfu_cache_with_lru_ties_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import lfuc_pkg::*;

	localparam int ENTRIES        = 16;
	localparam int COUNT_BITS     = 16;
	localparam int LATENCY        = ENTRIES + 3;
	localparam int KEY_POOL       = 24;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [KEY_TAG_W-1:0] key_tag;
		logic [VALUE_W-1:0]   write_value;
	} cache_request_t;

	typedef struct packed {
		logic                 hit;
		logic [VALUE_W-1:0]   read_value;
		logic                 evicted;
		logic [KEY_TAG_W-1:0] evicted_key;
	} cache_response_t;

	logic clk = 1'b0;
	logic arst_n;

	lfuc_req_if req_ch ();
	lfuc_rsp_if rsp_ch ();
	lfuc_cfg_if cfg_ch ();

	lfu_cache_with_lru_ties_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// shadow cache
	logic                  shadow_valid [ENTRIES];
	logic [KEY_TAG_W-1:0]  shadow_key   [ENTRIES];
	logic [VALUE_W-1:0]    shadow_value [ENTRIES];
	logic [COUNT_BITS-1:0] shadow_count [ENTRIES];
	logic [STAMP_W-1:0]    shadow_stamp [ENTRIES];
	logic [STAMP_W-1:0]    next_stamp;
	logic [CAP_W-1:0]      capacity;

	cache_request_t  queued_requests [$];
	cache_response_t awaited_responses [$];
	cache_request_t  next_request;
	logic [KEY_TAG_W-1:0] key_pool [KEY_POOL];

	int  outstanding = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  send_gap = 0;
	int  accept_stall = 0;
	int  sent_count = 0;
	bit  request_taken = 0;
	bit  capacity_taken = 0;
	bit  allow_idle = 1;
	bit  idle_stretch = 1;

	function automatic cache_response_t predict_access(cache_request_t r);
		cache_response_t res;
		int cap, used, found, victim, slot;
		logic [STAMP_W-1:0] age_i, age_v;
		res = '0;
		cap = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
		if (cap == 0)
			return res;
		used = 0;
		found = -1;
		victim = -1;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (shadow_valid[i]) begin
				used++;
				if (found < 0 && shadow_key[i] == r.key_tag)
					found = i;
			end
		end
		if (found >= 0) begin
			res.hit = 1'b1;
			if (r.command == CMD_GET)
				res.read_value = shadow_value[found];
			else
				shadow_value[found] = r.write_value;
			if (shadow_count[found] != '1)
				shadow_count[found]++;
			shadow_stamp[found] = next_stamp;
			next_stamp++;
			return res;
		end
		if (r.command == CMD_GET)
			return res;
		if (used >= cap) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (shadow_valid[i]) begin
					age_i = next_stamp - shadow_stamp[i];
					if (victim >= 0)
						age_v = next_stamp - shadow_stamp[victim];
					if (victim < 0 || shadow_count[i] < shadow_count[victim]
					    || (shadow_count[i] == shadow_count[victim] && age_i > age_v))
						victim = i;
				end
			end
			if (victim >= 0) begin
				res.evicted = 1'b1;
				res.evicted_key = shadow_key[victim];
				shadow_valid[victim] = 1'b0;
				slot = victim;
			end
		end
		if (slot < 0) begin
			for (int i = ENTRIES - 1; i >= 0; i--)
				if (!shadow_valid[i])
					slot = i;
		end
		if (slot >= 0) begin
			shadow_valid[slot] = 1'b1;
			shadow_key[slot] = r.key_tag;
			shadow_value[slot] = r.write_value;
			shadow_count[slot] = COUNT_BITS'(1);
			shadow_stamp[slot] = next_stamp;
			next_stamp++;
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (!allow_idle || !idle_stretch)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	function automatic void queue_request(logic [CMD_W-1:0] command,
	                                      logic [KEY_TAG_W-1:0] key_tag,
	                                      logic [VALUE_W-1:0] write_value);
		cache_request_t r;
		r.command = command;
		r.key_tag = key_tag;
		r.write_value = write_value;
		queued_requests.push_back(r);
		outstanding++;
	endfunction

	function automatic void queue_random(int span);
		logic [CMD_W-1:0] command;
		logic [KEY_TAG_W-1:0] key_tag;
		logic [VALUE_W-1:0] write_value;
		int roll;
		command = ($urandom_range(0, 99) < 45) ? CMD_SET : CMD_GET;
		if ($urandom_range(0, 99) < 85)
			key_tag = key_pool[$urandom_range(0, span)];
		else
			key_tag = $urandom;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			write_value = {VALUE_W{1'b0}};
		else if (roll == 1)
			write_value = {VALUE_W{1'b1}};
		else
			write_value = {$urandom, $urandom};
		queue_request(command, key_tag, write_value);
	endfunction

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		capacity_taken = 0;
		@(negedge clk);
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		@(negedge clk);
		while (!capacity_taken)
			@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (outstanding != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(req_ch.valid && !request_taken)) begin
				if (req_ch.valid) begin
					request_taken = 0;
					send_gap = pick_gap();
					sent_count++;
					if (sent_count % 64 == 0)
						idle_stretch = ($urandom_range(0, 3) != 0);
				end
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (queued_requests.size() != 0) begin
					next_request = queued_requests.pop_front();
					req_ch.command <= next_request.command;
					req_ch.key_tag <= next_request.key_tag;
					req_ch.write_value <= next_request.write_value;
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (accept_stall > 0) begin
				accept_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				accept_stall = pick_gap();
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		cache_request_t  seen_request;
		cache_response_t want;
		bit activity;
		activity = 0;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				activity = 1;
				if (awaited_responses.size() == 0) begin
					$display("%0t: response with none expected: hit %b read_value %h",
					         $time, rsp_ch.hit, rsp_ch.read_value);
					$display("%0t: evicted %b evicted_key %h",
					         $time, rsp_ch.evicted, rsp_ch.evicted_key);
					mismatches++;
				end else begin
					want = awaited_responses.pop_front();
					check_field("hit", 64'(want.hit), 64'(rsp_ch.hit));
					check_field("read_value", want.read_value, rsp_ch.read_value);
					check_field("evicted", 64'(want.evicted), 64'(rsp_ch.evicted));
					check_field("evicted_key", 64'(want.evicted_key),
					            64'(rsp_ch.evicted_key));
					if (outstanding > 0)
						outstanding--;
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				activity = 1;
				seen_request.command = req_ch.command;
				seen_request.key_tag = req_ch.key_tag;
				seen_request.write_value = req_ch.write_value;
				awaited_responses.push_back(predict_access(seen_request));
				request_taken = 1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				activity = 1;
				capacity = cfg_ch.data;
				capacity_taken = 1;
			end
		end
		if (activity) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase_capacity [10];
		int eff;
		phase_capacity = '{16, 4, 31, 1, 0, 17, 12, 2, 16, 7};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_GET;
		req_ch.key_tag = '0;
		req_ch.write_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = CAP_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i] = '0;
			shadow_value[i] = '0;
			shadow_count[i] = '0;
			shadow_stamp[i] = '0;
		end
		next_stamp = '0;
		capacity = CAP_RESET;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes, update, lookups at reset capacity
		queue_request(CMD_GET, 32'h0000_0000, 64'h0);
		queue_request(CMD_SET, 32'h0000_0000, 64'h0);
		queue_request(CMD_SET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(CMD_GET, 32'hFFFF_FFFF, 64'h0);
		queue_request(CMD_GET, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(CMD_SET, 32'h0000_0000, 64'h0123_4567_89AB_CDEF);
		queue_request(CMD_GET, 32'h0000_0000, 64'h0);
		queue_request(CMD_GET, 32'h0000_0005, 64'h0);
		drain();

		// fill, evict lowest count, break a count tie by age
		write_capacity(5'd3);
		queue_request(CMD_SET, 32'h0000_0001, 64'h11);
		queue_request(CMD_SET, 32'h0000_0002, 64'h22);
		queue_request(CMD_SET, 32'h0000_0003, 64'h33);
		queue_request(CMD_GET, 32'h0000_0003, 64'h0);
		queue_request(CMD_SET, 32'h0000_0004, 64'h44);
		queue_request(CMD_GET, 32'hFFFF_FFFF, 64'h0);
		drain();

		// disabled cache
		write_capacity(5'd0);
		queue_request(CMD_GET, 32'h0000_0000, 64'h0);
		queue_request(CMD_SET, 32'h0000_0009, 64'h99);
		drain();

		// capacity below occupancy
		write_capacity(5'd1);
		queue_request(CMD_GET, 32'h0000_0003, 64'h0);
		queue_request(CMD_SET, 32'h0000_0007, 64'h77);
		queue_request(CMD_SET, 32'h0000_0008, 64'h88);
		queue_request(CMD_GET, 32'h0000_0000, 64'h0);
		drain();

		foreach (phase_capacity[p]) begin
			write_capacity(CAP_W'(phase_capacity[p]));
			eff = (phase_capacity[p] > ENTRIES) ? ENTRIES : phase_capacity[p];
			repeat ((phase_capacity[p] == 0) ? 20 : 76)
				queue_random((eff == 0) ? 5 : eff + 3);
			drain();
		end

		// pile uses on one entry back to back, then force evictions around it
		write_capacity(5'd4);
		allow_idle = 0;
		queue_request(CMD_SET, 32'hA5A5_0001, 64'hDEAD_BEEF_0000_0001);
		repeat (12)
			queue_request(CMD_GET, 32'hA5A5_0001, 64'h0);
		drain();
		allow_idle = 1;
		write_capacity(5'd2);
		queue_request(CMD_SET, 32'hA5A5_0002, 64'h2);
		queue_request(CMD_SET, 32'hA5A5_0003, 64'h3);
		queue_request(CMD_SET, 32'hA5A5_0004, 64'h4);
		queue_request(CMD_GET, 32'hA5A5_0001, 64'h0);
		queue_request(CMD_SET, 32'hA5A5_0001, 64'h5);
		queue_request(CMD_GET, 32'hA5A5_0001, 64'h0);
		drain();

		if (mismatches == 0 && awaited_responses.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/lfuc_pkg.sv
sv/lfuc_if.sv
sv/lfuc_ram.sv
sv/lfu_cache_with_lru_ties_unit.sv
verif/tb_lfu_cache_with_lru_ties_unit.sv
